// ===== design/escaped_frame_time_decoder_unit_macros.svh =====
// Assertion macros used by the decoder top module.
`ifndef ESCAPED_FRAME_TIME_DECODER_UNIT_MACROS_SVH
`define ESCAPED_FRAME_TIME_DECODER_UNIT_MACROS_SVH

// Implication in the same cycle.
`define EFTD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Implication checked in the next cycle.
`define EFTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ===== design/eftd_pkg.sv =====
package eftd_pkg;

	typedef struct packed {
		logic [7:0] start_marker;
		logic [7:0] end_marker;
		logic [7:0] escape_byte;
		logic [7:0] hello_code;
		logic [7:0] time_code;
	} cfg_t;

	localparam logic [2:0] CFG_START  = 3'd0;
	localparam logic [2:0] CFG_END    = 3'd1;
	localparam logic [2:0] CFG_ESCAPE = 3'd2;
	localparam logic [2:0] CFG_HELLO  = 3'd3;
	localparam logic [2:0] CFG_TIME   = 3'd4;

	localparam logic [7:0] START_RESET  = 8'd255;
	localparam logic [7:0] END_RESET    = 8'd254;
	localparam logic [7:0] ESCAPE_RESET = 8'd253;
	localparam logic [7:0] HELLO_RESET  = 8'd0;
	localparam logic [7:0] TIME_RESET   = 8'd1;

	localparam logic [2:0] REP_HELLO   = 3'd0;
	localparam logic [2:0] REP_TIME    = 3'd1;
	localparam logic [2:0] REP_BADLEN  = 3'd2;
	localparam logic [2:0] REP_UNKNOWN = 3'd3;
	localparam logic [2:0] REP_BROKEN  = 3'd4;

	localparam logic [7:0]  LEN_OFFSET  = 8'd2;
	localparam logic [7:0]  TIME_LEN    = 8'd6;
	localparam logic [31:0] ROUND_LIMIT = 32'd6000;
	localparam logic [31:0] ROUND_ADD   = 32'd99;
	localparam logic [12:0] HUND_PER_MIN = 13'd6000;
	localparam logic [12:0] HUND_PER_SEC = 13'd100;
	// ceil(2^45 / 6000) and ceil(2^22 / 100)
	localparam logic [32:0] RECIP_MIN = 33'd5864062015;
	localparam logic [15:0] RECIP_SEC = 16'd41944;

	typedef struct packed {
		logic [2:0]  report;
		logic [31:0] count;
	} rec_t;

endpackage

// ===== design/eftd_front.sv =====
module eftd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  eftd_pkg::cfg_t cfg,
	input  logic           in_valid,
	input  logic [7:0]     rx_byte,
	input  logic           q_full,
	output logic           in_stall,
	output logic           push,
	output eftd_pkg::rec_t rec
);
	import eftd_pkg::*;

	logic        in_frame_q;
	logic        esc_q;
	logic [2:0]  cnt_q;
	logic [7:0]  len_q;
	logic [7:0]  cmd_q;
	logic [31:0] acc_q;
	logic        take;
	logic        is_start;
	logic        is_end;
	logic        is_esc;
	logic        dec_en;
	logic [7:0]  dec_byte;

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;
	assign is_start = !in_frame_q && (rx_byte == cfg.start_marker);
	assign is_end   = in_frame_q && !esc_q && (rx_byte == cfg.end_marker);
	assign is_esc   = in_frame_q && !esc_q && !is_end && (rx_byte == cfg.escape_byte);
	assign dec_en   = in_frame_q && (esc_q || (!is_end && !is_esc));
	assign dec_byte = esc_q ? 8'(cfg.escape_byte + rx_byte) : rx_byte;
	assign push     = take && is_end;

	always_comb begin
		rec.count = acc_q;
		if (cnt_q < 3'd2) begin
			rec.report = REP_BROKEN;
		end else if (cmd_q == cfg.hello_code) begin
			rec.report = REP_HELLO;
		end else if (cmd_q == cfg.time_code) begin
			if (len_q != TIME_LEN) begin
				rec.report = REP_BADLEN;
			end else if (cnt_q < 3'd6) begin
				rec.report = REP_BROKEN;
			end else begin
				rec.report = REP_TIME;
			end
		end else begin
			rec.report = REP_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			cnt_q      <= 3'd0;
			len_q      <= 8'd0;
			cmd_q      <= 8'd0;
			acc_q      <= 32'd0;
		end else if (take) begin
			if (is_start) begin
				in_frame_q <= 1'b1;
				esc_q      <= 1'b0;
				cnt_q      <= 3'd0;
				len_q      <= 8'd0;
				cmd_q      <= 8'd0;
				acc_q      <= 32'd0;
			end else if (is_end) begin
				in_frame_q <= 1'b0;
				esc_q      <= 1'b0;
			end else if (is_esc) begin
				esc_q <= 1'b1;
			end else if (dec_en) begin
				esc_q <= 1'b0;
				case (cnt_q)
					3'd0: len_q <= 8'(dec_byte - LEN_OFFSET);
					3'd1: cmd_q <= dec_byte;
					3'd2: acc_q[7:0]   <= acc_q[7:0] | dec_byte;
					3'd3: acc_q[15:8]  <= acc_q[15:8] | dec_byte;
					3'd4: acc_q[23:16] <= acc_q[23:16] | dec_byte;
					3'd5: acc_q[31:24] <= acc_q[31:24] | dec_byte;
					default: ;
				endcase
				if (cnt_q != 3'd7) begin
					cnt_q <= 3'(cnt_q + 3'd1);
				end
			end
		end
	end

endmodule

// ===== design/eftd_fifo.sv =====
module eftd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  eftd_pkg::rec_t din,
	output logic           full,
	input  logic           pop,
	output eftd_pkg::rec_t dout,
	output logic           empty
);
	import eftd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	rec_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : PW'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : PW'(rd_q + 1'b1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= CW'(cnt_q + 1'b1);
				2'b01:   cnt_q <= CW'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/eftd_back.sv =====
module eftd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  eftd_pkg::rec_t q_data,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [2:0]     report,
	output logic [19:0]    minutes,
	output logic [5:0]     seconds,
	output logic [6:0]     hundredths,
	output logic           show_minutes
);
	import eftd_pkg::*;

	logic        adv;
	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0]  rep_s1, rep_s2, rep_s3, rep_s4, rep_s5;
	logic [31:0] t_s1, t_s2, t_s3;
	logic [48:0] ph_s2, pl_s2;
	logic [19:0] m_s3, m_s4, m_s5;
	logic [12:0] rem_s4, rem_s5;
	logic [5:0]  sec_s5;
	logic [31:0] t_in;
	logic [64:0] sum_min;
	logic [32:0] mul_min;
	logic [28:0] mul_sec;
	logic [12:0] mul_cent;
	logic        out_valid_q;
	logic [2:0]  report_q;
	logic [19:0] minutes_q;
	logic [5:0]  seconds_q;
	logic [6:0]  hundredths_q;
	logic        show_q;

	assign adv  = !out_valid_q || !out_stall;
	assign pop  = adv && !q_empty;
	assign t_in = (q_data.count > ROUND_LIMIT) ? 32'(q_data.count + ROUND_ADD) : q_data.count;

	assign sum_min  = {ph_s2, 16'd0} + {16'd0, pl_s2};
	assign mul_min  = 33'(m_s3) * 33'(HUND_PER_MIN);
	assign mul_sec  = 29'(rem_s4) * 29'(RECIP_SEC);
	assign mul_cent = 13'(sec_s5) * HUND_PER_SEC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= !q_empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rep_s1 <= q_data.report;
			t_s1   <= t_in;

			rep_s2 <= rep_s1;
			t_s2   <= t_s1;
			ph_s2  <= 49'(t_s1[31:16]) * 49'(RECIP_MIN);
			pl_s2  <= 49'(t_s1[15:0]) * 49'(RECIP_MIN);

			rep_s3 <= rep_s2;
			t_s3   <= t_s2;
			m_s3   <= sum_min[64:45];

			rep_s4 <= rep_s3;
			m_s4   <= m_s3;
			rem_s4 <= 13'(t_s3 - mul_min[31:0]);

			rep_s5 <= rep_s4;
			m_s5   <= m_s4;
			rem_s5 <= rem_s4;
			sec_s5 <= mul_sec[27:22];

			report_q <= rep_s5;
			if (rep_s5 == REP_TIME) begin
				minutes_q    <= m_s5;
				seconds_q    <= sec_s5;
				hundredths_q <= 7'(rem_s5 - mul_cent);
				show_q       <= (m_s5 != 20'd0);
			end else begin
				minutes_q    <= 20'd0;
				seconds_q    <= 6'd0;
				hundredths_q <= 7'd0;
				show_q       <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign report       = report_q;
	assign minutes      = minutes_q;
	assign seconds      = seconds_q;
	assign hundredths   = hundredths_q;
	assign show_minutes = show_q;

endmodule

// ===== design/escaped_frame_time_decoder_unit.sv =====
// Escaped frame time decoder.
// Input channel: one raw byte per item on rx_byte, in_valid/in_stall.
// Output channel: one result item per closed frame on report, minutes,
// seconds, hundredths, show_minutes, with out_valid/out_stall.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 start marker,
// 1 end marker, 2 escape byte, 3 hello code, 4 time code) and cfg_data;
// cfg_ready is always high, unknown indexes are ignored.
// Throughput: one byte per cycle through the frame tracker while in_stall is low.
// After its end marker is taken, a result passes the queue slot, then the
// arithmetic stages s1 to s5 and the output register of the reporter.
// A queue of QUEUE_DEPTH frame records sits between tracker and reporter.
// When out_stall and out_valid are both high the reporter pipeline holds;
// the tracker keeps taking bytes until the queue fills, then raises in_stall.
// Reset: out of frame, queue and pipeline empty, registers at their
// default values (255, 254, 253, 0, 1).
module escaped_frame_time_decoder_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  report,
	output logic [19:0] minutes,
	output logic [5:0]  seconds,
	output logic [6:0]  hundredths,
	output logic        show_minutes
);
	import eftd_pkg::*;

	`include "escaped_frame_time_decoder_unit_macros.svh"

	cfg_t cfg_q;
	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	rec_t rec_in;
	rec_t rec_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker <= START_RESET;
			cfg_q.end_marker   <= END_RESET;
			cfg_q.escape_byte  <= ESCAPE_RESET;
			cfg_q.hello_code   <= HELLO_RESET;
			cfg_q.time_code    <= TIME_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START:  cfg_q.start_marker <= cfg_data;
				CFG_END:    cfg_q.end_marker   <= cfg_data;
				CFG_ESCAPE: cfg_q.escape_byte  <= cfg_data;
				CFG_HELLO:  cfg_q.hello_code   <= cfg_data;
				CFG_TIME:   cfg_q.time_code    <= cfg_data;
				default: ;
			endcase
		end
	end

	eftd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.in_stall (in_stall),
		.push     (push),
		.rec      (rec_in)
	);

	eftd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (rec_in),
		.full   (q_full),
		.pop    (pop),
		.dout   (rec_out),
		.empty  (q_empty)
	);

	eftd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (rec_out),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.report       (report),
		.minutes      (minutes),
		.seconds      (seconds),
		.hundredths   (hundredths),
		.show_minutes (show_minutes)
	);

	`EFTD_ASSERT_IMP(a_non_time_zero, clk, arst_n, out_valid && (report != REP_TIME), (minutes == 20'd0) && (seconds == 6'd0) && (hundredths == 7'd0) && !show_minutes)
	`EFTD_ASSERT_IMP(a_time_range, clk, arst_n, out_valid && (report == REP_TIME), (seconds < 6'd60) && (hundredths < 7'd100))
	`EFTD_ASSERT_IMP(a_show_match, clk, arst_n, out_valid, show_minutes == (minutes != 20'd0))
	`EFTD_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !q_full)

endmodule

// ===== tb/sv/escaped_frame_time_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

module escaped_frame_time_decoder_unit_tb;
	import eftd_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_BYTES   = 170;

	typedef struct packed {
		logic [2:0]  report;
		logic [19:0] minutes;
		logic [5:0]  seconds;
		logic [6:0]  hundredths;
		logic        show_minutes;
	} time_report_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  report;
	logic [19:0] minutes;
	logic [5:0]  seconds;
	logic [6:0]  hundredths;
	logic        show_minutes;

	escaped_frame_time_decoder_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.report      (report),
		.minutes     (minutes),
		.seconds     (seconds),
		.hundredths  (hundredths),
		.show_minutes(show_minutes)
	);

	cfg_t         cfg;
	logic         in_frame;
	logic         esc_pend;
	logic [2:0]   n_dec;
	logic [7:0]   len_b;
	logic [7:0]   cmd_b;
	logic [31:0]  acc;
	time_report_t pending_reports[$];
	logic [7:0]   frame_data[$];
	int           bytes_sent;
	int           mismatches;
	int           cycle_count;
	int           in_gap_pct;
	int           out_gap_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** escaped_frame_time_decoder_unit: FAILED **");
			$finish;
		end
	end

	function automatic time_report_t frame_report();
		time_report_t r;
		logic [31:0]  t;
		logic [31:0]  m;
		logic [31:0]  rest;
		logic [31:0]  s;
		r = '0;
		if (n_dec < 3'd2) begin
			r.report = REP_BROKEN;
		end else if (cmd_b == cfg.hello_code) begin
			r.report = REP_HELLO;
		end else if (cmd_b == cfg.time_code) begin
			if (len_b != TIME_LEN) begin
				r.report = REP_BADLEN;
			end else if (n_dec < 3'd6) begin
				r.report = REP_BROKEN;
			end else begin
				t = acc;
				if (t > ROUND_LIMIT)
					t = t + ROUND_ADD;
				m = t / 32'd6000;
				rest = t - m * 32'd6000;
				s = rest / 32'd100;
				r.report = REP_TIME;
				r.minutes = m[19:0];
				r.seconds = s[5:0];
				r.hundredths = 7'(rest - s * 32'd100);
				r.show_minutes = (m != 32'd0);
			end
		end else begin
			r.report = REP_UNKNOWN;
		end
		return r;
	endfunction

	task automatic store_decoded(input logic [7:0] d);
		case (n_dec)
			3'd0: len_b = d - LEN_OFFSET;
			3'd1: cmd_b = d;
			3'd2, 3'd3, 3'd4, 3'd5: acc = acc | ({24'd0, d} << (8 * (n_dec - 3'd2)));
			default: ;
		endcase
		if (n_dec != 3'd7)
			n_dec = n_dec + 3'd1;
	endtask

	task automatic track_rx_byte(input logic [7:0] b);
		logic [7:0] d;
		if (!in_frame) begin
			if (b == cfg.start_marker) begin
				in_frame = 1'b1;
				esc_pend = 1'b0;
				n_dec = 3'd0;
				len_b = 8'd0;
				cmd_b = 8'd0;
				acc = 32'd0;
			end
		end else if (esc_pend) begin
			esc_pend = 1'b0;
			d = cfg.escape_byte + b;
			store_decoded(d);
		end else if (b == cfg.end_marker) begin
			pending_reports.push_back(frame_report());
			in_frame = 1'b0;
			esc_pend = 1'b0;
		end else if (b == cfg.escape_byte) begin
			esc_pend = 1'b1;
		end else begin
			store_decoded(b);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		time_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with none expected: report %0d", report);
			end else begin
				want = pending_reports.pop_front();
				check_field("report", want.report, report);
				check_field("minutes", want.minutes, minutes);
				check_field("seconds", want.seconds, seconds);
				check_field("hundredths", want.hundredths, hundredths);
				check_field("show_minutes", want.show_minutes, show_minutes);
			end
		end
	end

	initial begin
		int left;
		left = 0;
		forever begin
			@(posedge clk);
			if (left == 0 && out_gap_pct != 0 && $urandom_range(0, 99) < out_gap_pct / 4)
				left = $urandom_range(1, 14);
			if (left != 0) begin
				out_stall <= 1'b1;
				left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		track_rx_byte(b);
		bytes_sent++;
	endtask

	task automatic send_data(input logic [7:0] d, input bit force_esc);
		if (force_esc || d == cfg.end_marker || d == cfg.escape_byte) begin
			send_byte(cfg.escape_byte);
			send_byte(d - cfg.escape_byte);
		end else begin
			send_byte(d);
		end
	endtask

	task automatic send_frame(input bit random_esc);
		send_byte(cfg.start_marker);
		foreach (frame_data[i])
			send_data(frame_data[i], random_esc && $urandom_range(0, 15) == 0);
		send_byte(cfg.end_marker);
		frame_data.delete();
	endtask

	task automatic queue_time(input logic [31:0] count);
		frame_data.push_back(TIME_LEN + LEN_OFFSET);
		frame_data.push_back(cfg.time_code);
		for (int i = 0; i < 4; i++)
			frame_data.push_back(count[8*i +: 8]);
	endtask

	task automatic queue_pair(input logic [7:0] len_raw, input logic [7:0] cmd);
		frame_data.push_back(len_raw);
		frame_data.push_back(cmd);
	endtask

	task automatic add_random(input int lo, input int hi);
		repeat ($urandom_range(lo, hi))
			frame_data.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_START:  cfg.start_marker = val;
			CFG_END:    cfg.end_marker = val;
			CFG_ESCAPE: cfg.escape_byte = val;
			CFG_HELLO:  cfg.hello_code = val;
			CFG_TIME:   cfg.time_code = val;
			default: ;
		endcase
	endtask

	task automatic write_config(input cfg_t c);
		write_reg(CFG_START, c.start_marker);
		write_reg(CFG_END, c.end_marker);
		write_reg(CFG_ESCAPE, c.escape_byte);
		write_reg(CFG_HELLO, c.hello_code);
		write_reg(CFG_TIME, c.time_code);
		for (int i = CFG_TIME + 1; i < 8; i++)
			write_reg(i[2:0], 8'($urandom_range(0, 255)));
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic cfg_t random_config();
		cfg_t c;
		c.start_marker = 8'($urandom_range(0, 255));
		c.end_marker = 8'($urandom_range(0, 255));
		c.escape_byte = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 7) != 0) begin
			while (c.end_marker == c.start_marker)
				c.end_marker = 8'($urandom_range(0, 255));
			while (c.escape_byte == c.start_marker || c.escape_byte == c.end_marker)
				c.escape_byte = 8'($urandom_range(0, 255));
		end
		c.hello_code = 8'($urandom_range(0, 255));
		c.time_code = ($urandom_range(0, 9) == 0) ? c.hello_code : 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic int random_gap_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 5;
			2: return 25;
			default: return 60;
		endcase
	endfunction

	task automatic gen_frame();
		int          kind;
		logic [31:0] count;
		logic [7:0]  len_raw;
		repeat ($urandom_range(0, 2))
			send_byte(8'($urandom_range(0, 255)));
		kind = $urandom_range(0, 99);
		if (kind >= 94) begin
			send_byte(cfg.start_marker);
			repeat ($urandom_range(1, 8))
				send_byte(8'($urandom_range(0, 255)));
			send_byte(cfg.end_marker);
			return;
		end
		if (kind < 45) begin
			case ($urandom_range(0, 3))
				0: count = $urandom;
				1: count = $urandom_range(0, 12000);
				2: count = $urandom_range(5990, 6010);
				default: count = 32'hFFFF_FFFF - $urandom_range(0, 200);
			endcase
			queue_time(count);
			if ($urandom_range(0, 4) == 0)
				add_random(1, 3);
		end else if (kind < 60) begin
			queue_pair(8'($urandom_range(0, 255)), cfg.hello_code);
			add_random(0, 5);
		end else if (kind < 70) begin
			len_raw = 8'($urandom_range(0, 255));
			while (len_raw == TIME_LEN + LEN_OFFSET)
				len_raw = 8'($urandom_range(0, 255));
			queue_pair(len_raw, cfg.time_code);
			add_random(0, 6);
		end else if (kind < 78) begin
			queue_pair(TIME_LEN + LEN_OFFSET, cfg.time_code);
			add_random(0, 3);
		end else if (kind < 88) begin
			add_random(2, 8);
		end else begin
			add_random(0, 1);
		end
		send_frame(1'b1);
	endtask

	task automatic test_default_reports();
		send_byte(8'h00);
		send_byte(8'h12);
		send_byte(cfg.end_marker);
		queue_pair(8'd2, cfg.hello_code);
		send_frame(1'b0);
		queue_pair(8'd7, cfg.time_code);
		send_frame(1'b0);
		queue_pair(8'd2, 8'h55);
		send_frame(1'b0);
		send_frame(1'b0);
		frame_data.push_back(8'h08);
		send_frame(1'b0);
		queue_pair(TIME_LEN + LEN_OFFSET, cfg.time_code);
		frame_data.push_back(8'h10);
		send_frame(1'b0);
		settle();
	endtask

	task automatic test_time_rounding();
		logic [31:0] counts[8];
		counts = '{32'd0, 32'd99, 32'd6000, 32'd6001, 32'd359999,
			32'hFFFF_FF9C, 32'hFFFF_FF9D, 32'hFFFF_FFFF};
		foreach (counts[i]) begin
			queue_time(counts[i]);
			send_frame(1'b0);
		end
		settle();
	endtask

	task automatic test_escaping();
		queue_time(32'hFCFD_FEFF);
		send_frame(1'b0);
		send_byte(cfg.start_marker);
		send_data(TIME_LEN + LEN_OFFSET, 1'b0);
		send_data(cfg.time_code, 1'b0);
		send_byte(cfg.escape_byte);
		send_byte(cfg.end_marker);
		send_byte(cfg.escape_byte);
		send_byte(cfg.start_marker);
		send_byte(cfg.escape_byte);
		send_byte(cfg.escape_byte);
		send_data(8'h00, 1'b1);
		send_byte(cfg.end_marker);
		queue_time(32'd12345);
		frame_data.push_back(8'h07);
		frame_data.push_back(8'h80);
		frame_data.push_back(8'hFF);
		send_frame(1'b0);
		settle();
	endtask

	task automatic test_register_extremes();
		write_config('{8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00});
		send_byte(8'hFF);
		queue_pair(8'd2, cfg.hello_code);
		send_frame(1'b0);
		queue_time(32'd6099);
		send_frame(1'b0);
		queue_time(32'h00FF_8000);
		send_frame(1'b0);
		settle();
		write_config('{8'h55, 8'h00, 8'hFF, 8'hA5, 8'hA5});
		queue_pair(8'd2, 8'hA5);
		send_frame(1'b0);
		queue_time(32'd1234);
		send_frame(1'b0);
		queue_pair(TIME_LEN + LEN_OFFSET, 8'h5A);
		send_frame(1'b0);
		settle();
	endtask

	task automatic test_random_frames();
		int first;
		for (int phase = 0; phase < 8; phase++) begin
			write_config(random_config());
			in_gap_pct = random_gap_pct();
			out_gap_pct = random_gap_pct();
			first = bytes_sent;
			while (bytes_sent - first < PHASE_BYTES)
				gen_frame();
			settle();
		end
	endtask

	task automatic test_back_to_back();
		int first;
		in_gap_pct = 0;
		out_gap_pct = 0;
		write_config('{START_RESET, END_RESET, ESCAPE_RESET, HELLO_RESET, TIME_RESET});
		first = bytes_sent;
		while (bytes_sent - first < PHASE_BYTES)
			gen_frame();
		settle();
	endtask

	initial begin
		cfg = '{START_RESET, END_RESET, ESCAPE_RESET, HELLO_RESET, TIME_RESET};
		in_frame = 1'b0;
		esc_pend = 1'b0;
		n_dec = 3'd0;
		len_b = 8'd0;
		cmd_b = 8'd0;
		acc = 32'd0;
		bytes_sent = 0;
		mismatches = 0;
		cycle_count = 0;
		in_gap_pct = 25;
		out_gap_pct = 25;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= 3'd0;
		cfg_data <= 8'd0;
		in_valid <= 1'b0;
		rx_byte <= 8'd0;
		out_stall <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_reports();
		test_time_rounding();
		test_escaping();
		test_register_extremes();
		test_random_frames();
		test_back_to_back();
		if (mismatches == 0 && pending_reports.size() == 0) begin
			$display("** escaped_frame_time_decoder_unit: PASSED **");
		end else begin
			$display("** escaped_frame_time_decoder_unit: FAILED **");
		end
		$finish;
	end

endmodule
